### hdl/pba_pkg.sv
// page bitmap allocator: shared constants, codes and types
// used by the register block, the engine, the top level and the testbench
package pba_pkg;

  localparam int MAX_PAGES = 65536;
  localparam int PAGE_BITS = 12;

  // map storage geometry, one 64-bit word holds 64 page bits
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = 6;
  localparam int WORDS     = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  // page index wide enough to hold the page count of the whole storage
  localparam int IDX_W     = WA_W + BIT_W + 1;
  // page number carried by a 32-bit address
  localparam int OFF_W     = 32 - PAGE_BITS;

  localparam int CNT_W     = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int REG_W     = 17;

  localparam int PW    = (REG_W > IDX_W) ? REG_W : IDX_W;
  localparam int CW    = ((OFF_W > IDX_W) ? OFF_W : IDX_W) + 1;
  localparam int SUM_W = ((OFF_W > CNT_W) ? OFF_W : CNT_W) + 1;

  localparam int PADDR_W = 4;

  typedef enum logic [1:0] {
    CMD_ALLOC       = 2'd0,
    CMD_FREE_PAGE   = 2'd1,
    CMD_RESERVE     = 2'd2,
    CMD_FREE_REGION = 2'd3
  } cmd_t;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_NOFREE   = 3'd1;
  localparam status_t ST_MISALIGN = 3'd2;
  localparam status_t ST_CONFLICT = 3'd3;
  localparam status_t ST_RANGE    = 3'd4;

  // register indexes, byte address is index * 4
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_PAGES = 2'd1;
  localparam logic [1:0] REG_TAIL  = 2'd2;

  typedef struct packed {
    logic [31:0]      base;
    logic [IDX_W-1:0] total;   // pages covered, clamped to storage
    logic [IDX_W-1:0] limit;   // pages searched by allocate
  } cfg_t;

  typedef struct packed {
    logic [31:0]      page_address;
    status_t          status;
    logic [CNT_W-1:0] pages_used;
  } res_t;

endpackage

### hdl/pba_ifs.sv
// valid/ready channels of the page bitmap allocator: command in, result out
// depends on pba_pkg for nothing but field widths written out here
interface pba_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] phys_address;
  logic [31:0] region_size;

  modport source (output valid, output cmd, output phys_address, output region_size,
                  input ready);
  modport sink (input valid, input cmd, input phys_address, input region_size,
                output ready);
endinterface

interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] page_address;
  logic [2:0]  status;
  logic [16:0] pages_used;

  modport source (output valid, output page_address, output status, output pages_used,
                  input ready);
  modport sink (input valid, input page_address, input status, input pages_used,
                output ready);
endinterface

### hdl/page_bitmap_allocator.sv
// top level of the page bitmap allocator: register block, engine, result register
// depends on pba_pkg, pba_ifs, pba_cfg_regs and pba_engine
//
//   channel    direction  kind         contents
//   in_item    in         valid/ready  cmd, phys_address, region_size
//   out_item   out        valid/ready  page_address, status, pages_used
//   cfg_*      in         apb          low_memory_base, pages_in_map, tail_reserved_pages
//
// after reset a clearing pass writes all WORDS map words (1024) before
// the first command transfer; register writes are taken during it.
// free page reads and rewrites one word, allocate scans 64-page words up to a free bit,
// regions check each word of the range and then write each one; failed checks end early.
// one command at a time; the map memory read port, one word a cycle, sets the scan rate.
// the result register frees the engine as soon as it hands over a result, so one
// result can wait on out_item while the next command is worked on.
module page_bitmap_allocator
  import pba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  pba_cmd_if.sink            in_item,
  pba_rsp_if.source          out_item,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  cfg_t cfg;
  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_r;
  res_t out_r;

  pba_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pba_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_item.valid        = out_valid_r;
  assign out_item.page_address = out_r.page_address;
  assign out_item.status       = out_r.status;
  assign out_item.pages_used   = out_r.pages_used;

endmodule

### hdl/pba_cfg_regs.sv
// apb register block: map base, map size, tail pages
// depends on pba_pkg; hands derived map bounds to the engine as cfg_t
module pba_cfg_regs
  import pba_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  logic [31:0]      base_r;
  logic [REG_W-1:0] pages_r;
  logic [REG_W-1:0] tail_r;
  logic             wr_en;
  logic [PW-1:0]    pages_x;
  logic [PW-1:0]    tail_x;
  logic [PW-1:0]    total_x;
  logic [PW-1:0]    limit_x;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      pages_r <= '0;
      tail_r  <= '0;
    end else if (wr_en && cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[3:2])
        REG_BASE:  base_r  <= cfg_pwdata;
        REG_PAGES: pages_r <= cfg_pwdata[REG_W-1:0];
        REG_TAIL:  tail_r  <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[1:0] == 2'b00) begin
      unique case (cfg_paddr[3:2])
        REG_BASE:  cfg_prdata = base_r;
        REG_PAGES: cfg_prdata = 32'(pages_r);
        REG_TAIL:  cfg_prdata = 32'(tail_r);
        default:   cfg_prdata = '0;
      endcase
    end
  end

  // map size clamps to the storage, allocate stops short of the tail
  always_comb begin
    pages_x = PW'(pages_r);
    tail_x  = PW'(tail_r);
    total_x = (pages_x > PW'(MAX_PAGES)) ? PW'(MAX_PAGES) : pages_x;
    limit_x = (total_x > tail_x) ? total_x - tail_x : '0;
  end

  assign cfg.base  = base_r;
  assign cfg.total = total_x[IDX_W-1:0];
  assign cfg.limit = limit_x[IDX_W-1:0];

endmodule

### hdl/pba_engine.sv
// bitmap engine: map memory of 64-bit words, clearing pass and command sequencer
// depends on pba_pkg and pba_cmd_if; result leaves as res_t with valid/ready
module pba_engine
  import pba_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cfg_t  cfg,
  pba_cmd_if.sink in_item,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_PREP    = 10'b0000000100,
    S_CHECK   = 10'b0000001000,
    S_SCAN    = 10'b0000010000,
    S_ADDR    = 10'b0000100000,
    S_FREE_WR = 10'b0001000000,
    S_CHK     = 10'b0010000000,
    S_APPLY   = 10'b0100000000,
    S_RESP    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic [WA_W-1:0]      rd_addr;
  logic                 wr_en;
  logic [WA_W-1:0]      wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  cmd_t             cmd_r;
  logic [31:0]      addr_r;
  logic [31:0]      size_r;
  logic             below_r, below_nxt;
  logic [OFF_W-1:0] pg_r, pg_nxt;
  logic [WA_W-1:0]  w_r, w_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  status_t          status_r, status_nxt;
  logic [31:0]      paddr_r, paddr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [32:0]          off;
  logic [OFF_W-1:0]     n_pg;
  logic                 misalign;
  logic [CW-1:0]        pg_x, tot_x, n_x, end_x;
  logic                 free_bad, region_bad;
  logic [IDX_W-1:0]     lim;
  logic [IDX_W-1:0]     next_base;
  logic                 last;
  logic [BIT_W-1:0]     lo, hi;
  logic [WORD_BITS-1:0] mask, free_bits, hit_bits, set_bit;
  logic [BIT_W-1:0]     hit_b;
  logic                 target;
  logic [OFF_W-1:0]     delta;
  logic [SUM_W-1:0]     sum;
  logic [CNT_W-1:0]     cnt_add, cnt_sub;

  // map memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign in_item.ready = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_RESP);
  assign res.page_address = paddr_r;
  assign res.status       = status_r;
  assign res.pages_used   = count_r;

  always_ff @(posedge clk) begin
    if (in_item.valid && state_r == S_IDLE) begin
      cmd_r  <= cmd_t'(in_item.cmd);
      addr_r <= in_item.phys_address;
      size_r <= in_item.region_size;
    end
  end

  // address checks
  always_comb begin
    off       = {1'b0, addr_r} - {1'b0, cfg.base};
    n_pg      = size_r[31:PAGE_BITS];
    misalign  = (addr_r[PAGE_BITS-1:0] != '0) || (size_r[PAGE_BITS-1:0] != '0);
    pg_x      = CW'(pg_r);
    tot_x     = CW'(cfg.total);
    n_x       = CW'(n_pg);
    end_x     = pg_x + n_x;
    free_bad  = below_r || (pg_x >= tot_x);
    region_bad = below_r || (pg_x > tot_x) || (n_x > tot_x - pg_x);
  end

  // per-word mask of the pages in play
  always_comb begin
    target    = (cmd_r == CMD_RESERVE);
    lim       = (state_r == S_SCAN) ? cfg.limit : end_r;
    next_base = {(({1'b0, w_r}) + (WA_W+1)'(1)), BIT_W'(0)};
    last      = (next_base >= lim);
    lo        = ((state_r != S_SCAN) && (w_r == first_r[BIT_W +: WA_W])) ?
                first_r[BIT_W-1:0] : '0;
    hi        = last ? (lim[BIT_W-1:0] - BIT_W'(1)) : '1;
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (BIT_W'(b) >= lo) && (BIT_W'(b) <= hi);
    end
    free_bits = ~rdata_r & mask;
    hit_bits  = (target ? rdata_r : ~rdata_r) & mask;
    hit_b     = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_b = BIT_W'(b);
      end
    end
    set_bit = WORD_BITS'(1) << hit_b;
  end

  // saturating used-page counter
  always_comb begin
    delta   = (state_r == S_APPLY) ? n_pg : OFF_W'(1);
    sum     = SUM_W'(count_r) + SUM_W'(delta);
    cnt_add = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
    cnt_sub = (SUM_W'(count_r) > SUM_W'(delta)) ? count_r - delta[CNT_W-1:0] : '0;
  end

  always_comb begin
    state_nxt  = state_r;
    below_nxt  = below_r;
    pg_nxt     = pg_r;
    w_nxt      = w_r;
    first_nxt  = first_r;
    end_nxt    = end_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    paddr_nxt  = paddr_r;
    count_nxt  = count_r;
    rd_addr    = w_r;
    wr_en      = 1'b0;
    wr_addr    = w_r;
    wr_data    = '0;

    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        w_nxt = w_r + WA_W'(1);
        if (w_r == WA_W'(WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_item.valid) begin
          status_nxt = ST_OK;
          paddr_nxt  = '0;
          state_nxt  = S_PREP;
        end
      end
      S_PREP: begin
        below_nxt = off[32];
        pg_nxt    = off[31:PAGE_BITS];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (cfg.limit == '0) begin
              status_nxt = ST_NOFREE;
              state_nxt  = S_RESP;
            end else begin
              w_nxt     = '0;
              rd_addr   = '0;
              state_nxt = S_SCAN;
            end
          end
          CMD_FREE_PAGE: begin
            if (free_bad) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end else begin
              w_nxt     = pg_x[BIT_W +: WA_W];
              rd_addr   = pg_x[BIT_W +: WA_W];
              idx_nxt   = pg_x[IDX_W-1:0];
              state_nxt = S_FREE_WR;
            end
          end
          default: begin
            if (misalign) begin
              status_nxt = ST_MISALIGN;
              state_nxt  = S_RESP;
            end else if (region_bad) begin
              status_nxt = ST_RANGE;
              state_nxt  = S_RESP;
            end else if (n_pg == '0) begin
              state_nxt = S_RESP;
            end else begin
              first_nxt = pg_x[IDX_W-1:0];
              end_nxt   = end_x[IDX_W-1:0];
              w_nxt     = pg_x[BIT_W +: WA_W];
              rd_addr   = pg_x[BIT_W +: WA_W];
              state_nxt = S_CHK;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          wr_en     = 1'b1;
          wr_data   = rdata_r | set_bit;
          idx_nxt   = {1'b0, w_r, hit_b};
          count_nxt = cnt_add;
          state_nxt = S_ADDR;
        end else if (last) begin
          status_nxt = ST_NOFREE;
          state_nxt  = S_RESP;
        end else begin
          w_nxt   = w_r + WA_W'(1);
          rd_addr = w_r + WA_W'(1);
        end
      end
      S_ADDR: begin
        paddr_nxt = cfg.base + (32'(idx_r) << PAGE_BITS);
        state_nxt = S_RESP;
      end
      S_FREE_WR: begin
        // count drops even when the bit was already clear
        wr_en     = 1'b1;
        wr_data   = rdata_r & ~(WORD_BITS'(1) << idx_r[BIT_W-1:0]);
        count_nxt = cnt_sub;
        state_nxt = S_RESP;
      end
      S_CHK: begin
        if (hit_bits != '0) begin
          status_nxt = ST_CONFLICT;
          state_nxt  = S_RESP;
        end else if (last) begin
          w_nxt     = first_r[BIT_W +: WA_W];
          rd_addr   = first_r[BIT_W +: WA_W];
          state_nxt = S_APPLY;
        end else begin
          w_nxt   = w_r + WA_W'(1);
          rd_addr = w_r + WA_W'(1);
        end
      end
      S_APPLY: begin
        // write word w while the next one is read
        wr_en   = 1'b1;
        wr_data = target ? (rdata_r | mask) : (rdata_r & ~mask);
        if (last) begin
          count_nxt = target ? cnt_add : cnt_sub;
          state_nxt = S_RESP;
        end else begin
          w_nxt   = w_r + WA_W'(1);
          rd_addr = w_r + WA_W'(1);
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      w_r     <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      w_r     <= w_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    below_r  <= below_nxt;
    pg_r     <= pg_nxt;
    first_r  <= first_nxt;
    end_r    <= end_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    paddr_r  <= paddr_nxt;
  end

endmodule

### tb/page_bitmap_allocator_tb.sv
// testbench for page_bitmap_allocator: directed and random commands with a bitmap predictor
// depends on pba_pkg, the pba_cmd_if / pba_rsp_if channels and the page_bitmap_allocator top
`timescale 1ns / 1ps

module page_bitmap_allocator_tb;
  import pba_pkg::*;

  localparam longint unsigned LIMIT_CYCLES = 20_000_000;
  localparam int unsigned TAIL_CYCLES = 100;

  typedef struct {
    cmd_t        op;
    logic [31:0] addr;
    logic [31:0] size;
  } cmd_item_t;

  logic clk;
  logic rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [31:0]        cfg_pwdata;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  pba_cmd_if in_item();
  pba_rsp_if out_item();

  page_bitmap_allocator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .out_item   (out_item),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // predictor state: register copies, page bitmap and used count
  logic [31:0]     cfg_base;
  logic [16:0]     cfg_pages;
  logic [16:0]     cfg_tail;
  bit              page_used [MAX_PAGES];
  longint unsigned used_count;

  cmd_item_t   cmd_backlog[$];
  res_t        due_results[$];
  logic [31:0] held_addr[$];
  logic [31:0] held_size[$];

  int unsigned send_gap;
  int unsigned recv_stall;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned errors;
  int unsigned n_settings;
  int unsigned n_op [4];
  int unsigned n_status [5];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned map_size();
    return (cfg_pages > MAX_PAGES) ? MAX_PAGES : cfg_pages;
  endfunction

  function automatic logic [31:0] page_at(input int unsigned idx);
    return cfg_base + (32'(idx) << PAGE_BITS);
  endfunction

  function automatic void count_up(input longint unsigned n);
    used_count = (used_count + n > CNT_MAX) ? CNT_MAX : used_count + n;
  endfunction

  function automatic void count_down(input longint unsigned n);
    used_count = (used_count > n) ? used_count - n : 0;
  endfunction

  // applies one command to the bitmap and returns the result it should produce
  function automatic res_t bitmap_apply(input cmd_t op, input logic [31:0] addr_in,
                                        input logic [31:0] size_in);
    res_t            r;
    longint unsigned base, addr, total, lim, first, npg, idx;
    bit              target;
    r.page_address = '0;
    r.status = ST_OK;
    base = cfg_base;
    addr = addr_in;
    total = map_size();
    case (op)
      CMD_ALLOC: begin
        lim = (total > cfg_tail) ? total - cfg_tail : 0;
        r.status = ST_NOFREE;
        for (idx = 0; idx < lim; idx++) begin
          if (!page_used[idx]) begin
            page_used[idx] = 1'b1;
            count_up(1);
            r.page_address = 32'(base + (idx << PAGE_BITS));
            r.status = ST_OK;
            break;
          end
        end
      end
      CMD_FREE_PAGE: begin
        if (addr < base || ((addr - base) >> PAGE_BITS) >= total) begin
          r.status = ST_RANGE;
        end else begin
          page_used[(addr - base) >> PAGE_BITS] = 1'b0;
          count_down(1);
        end
      end
      default: begin
        target = (op == CMD_RESERVE);
        npg = size_in >> PAGE_BITS;
        if (addr_in[PAGE_BITS-1:0] != '0 || size_in[PAGE_BITS-1:0] != '0) begin
          r.status = ST_MISALIGN;
        end else if (addr < base) begin
          r.status = ST_RANGE;
        end else begin
          first = (addr - base) >> PAGE_BITS;
          if (first > total || npg > total - first) begin
            r.status = ST_RANGE;
          end else begin
            // whole range is checked before anything is touched
            for (idx = first; idx < first + npg; idx++) begin
              if (page_used[idx] == target) begin
                r.status = ST_CONFLICT;
                break;
              end
            end
            if (r.status == ST_OK) begin
              for (idx = first; idx < first + npg; idx++) page_used[idx] = target;
              if (target) count_up(npg);
              else count_down(npg);
            end
          end
        end
      end
    endcase
    r.pages_used = CNT_W'(used_count);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // mostly short regions, a few reaching to or past the map end
  function automatic void pick_region(output logic [31:0] a, output logic [31:0] s);
    int unsigned total, first, r, n;
    total = map_size();
    first = (total == 0 || $urandom_range(0, 99) < 3) ? total : $urandom_range(0, total - 1);
    r = $urandom_range(0, 99);
    if (r < 80) n = $urandom_range(0, 6);
    else if (r < 95) n = $urandom_range(0, 64);
    else n = $urandom_range(0, total - first + 1);
    a = page_at(first);
    s = 32'(n) << PAGE_BITS;
  endfunction

  function automatic cmd_item_t rand_cmd();
    cmd_item_t   c;
    int unsigned sel, total, k;
    total = map_size();
    sel = $urandom_range(0, 99);
    c.addr = $urandom;
    c.size = $urandom;
    if (sel < 6) begin
      c.op = cmd_t'(2'($urandom_range(0, 3)));
      if ($urandom_range(0, 1)) begin
        c.addr[PAGE_BITS-1:0] = '0;
        c.size[PAGE_BITS-1:0] = '0;
      end
    end else if (sel < 40) begin
      c.op = CMD_ALLOC;
    end else if (sel < 58) begin
      c.op = CMD_FREE_PAGE;
      k = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, total);
      c.addr = page_at(k);
      if ($urandom_range(0, 1)) c.addr = c.addr + $urandom_range(0, (1 << PAGE_BITS) - 1);
    end else if (sel < 80) begin
      c.op = CMD_RESERVE;
      pick_region(c.addr, c.size);
      held_addr.push_back(c.addr);
      held_size.push_back(c.size);
    end else begin
      c.op = CMD_FREE_REGION;
      if (held_addr.size() != 0 && $urandom_range(0, 1)) begin
        k = $urandom_range(0, held_addr.size() - 1);
        c.addr = held_addr[k];
        c.size = held_size[k];
        held_addr.delete(k);
        held_size.delete(k);
      end else begin
        pick_region(c.addr, c.size);
      end
    end
    return c;
  endfunction

  task automatic queue_cmd(input cmd_t op, input logic [31:0] addr, input logic [31:0] size);
    cmd_item_t c;
    c.op = op;
    c.addr = addr;
    c.size = size;
    cmd_backlog.push_back(c);
  endtask

  // sender holds off until everything sent has come back
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_item.valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= PADDR_W'({idx, 2'b00});
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_BASE:  cfg_base = val;
      REG_PAGES: cfg_pages = val[16:0];
      REG_TAIL:  cfg_tail = val[16:0];
      default: ;
    endcase
  endtask

  task automatic set_cfg(input logic [31:0] base, input logic [16:0] pages,
                         input logic [16:0] tail, input bit in_gaps, input bit out_stalls);
    wait_idle();
    reg_write(REG_BASE, base);
    reg_write(REG_PAGES, 32'(pages));
    reg_write(REG_TAIL, 32'(tail));
    gaps_on = in_gaps;
    stalls_on = out_stalls;
    n_settings++;
  endtask

  task automatic random_phase(input logic [31:0] base, input logic [16:0] pages,
                              input logic [16:0] tail, input int unsigned count,
                              input bit in_gaps, input bit out_stalls);
    int unsigned k;
    set_cfg(base, pages, tail, in_gaps, out_stalls);
    held_addr.delete();
    held_size.delete();
    for (k = 0; k < count; k++) cmd_backlog.push_back(rand_cmd());
    wait_idle();
  endtask

  // command driver: next transfer offered once the previous one is taken
  always @(posedge clk) begin : drive_cmds
    cmd_item_t c;
    if (!rst_n) begin
      in_item.valid <= 1'b0;
      send_gap = 0;
    end else if (!in_item.valid || in_item.ready) begin
      if (send_gap > 0) begin
        in_item.valid <= 1'b0;
        send_gap--;
      end else if (cmd_backlog.size() != 0) begin
        c = cmd_backlog.pop_front();
        in_item.valid <= 1'b1;
        in_item.cmd <= c.op;
        in_item.phys_address <= c.addr;
        in_item.region_size <= c.size;
        send_gap = gaps_on ? pick_gap() : 0;
      end else begin
        in_item.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      recv_stall = 0;
    end else if (recv_stall > 0) begin
      out_item.ready <= 1'b0;
      recv_stall--;
    end else begin
      out_item.ready <= 1'b1;
      if (stalls_on) recv_stall = pick_gap();
    end
  end

  // results are checked before the command of the same edge is predicted
  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n) begin
      if (out_item.valid && out_item.ready) begin
        if (due_results.size() == 0) begin
          $error("result transfer with nothing outstanding: addr %h status %0d used %0d",
                 out_item.page_address, out_item.status, out_item.pages_used);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_item.page_address !== want.page_address) begin
            $error("page_address: expected %h, got %h", want.page_address,
                   out_item.page_address);
            errors++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.pages_used !== want.pages_used) begin
            $error("pages_used: expected %0d, got %0d", want.pages_used,
                   out_item.pages_used);
            errors++;
          end
        end
      end
      if (in_item.valid && in_item.ready) begin
        want = bitmap_apply(cmd_t'(in_item.cmd), in_item.phys_address, in_item.region_size);
        due_results.push_back(want);
        n_op[in_item.cmd]++;
        n_status[want.status]++;
      end
    end
  end

  initial begin : watchdog
    longint unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             due_results.size());
    $display("FAIL page_bitmap_allocator");
    $finish;
  end

  initial begin : main
    rst_n = 1'b0;
    in_item.valid = 1'b0;
    in_item.cmd = CMD_ALLOC;
    in_item.phys_address = '0;
    in_item.region_size = '0;
    out_item.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cfg_base = '0;
    cfg_pages = '0;
    cfg_tail = '0;
    used_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    errors = 0;
    n_settings = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // registers at reset: empty map
    queue_cmd(CMD_ALLOC, 32'h0, 32'h0);
    queue_cmd(CMD_RESERVE, 32'h0, 32'h0);
    queue_cmd(CMD_FREE_PAGE, 32'h0, 32'h0);

    set_cfg(32'h0010_0000, 17'd64, 17'd4, 1'b1, 1'b1);
    queue_cmd(CMD_ALLOC, $urandom, $urandom);
    queue_cmd(CMD_ALLOC, $urandom, $urandom);
    queue_cmd(CMD_FREE_PAGE, page_at(0) | 32'hFFF, 32'h0);   // offset bits ignored
    queue_cmd(CMD_FREE_PAGE, page_at(0) | 32'hABC, 32'h0);   // page already free
    queue_cmd(CMD_FREE_PAGE, page_at(1), 32'h0);             // count stays at zero
    queue_cmd(CMD_FREE_PAGE, 32'h000F_F000, 32'h0);
    queue_cmd(CMD_FREE_PAGE, page_at(64), 32'h0);
    queue_cmd(CMD_RESERVE, page_at(0) + 32'h10, 32'h1000);
    queue_cmd(CMD_RESERVE, page_at(56), 32'h800);
    queue_cmd(CMD_FREE_REGION, 32'h000F_F000, 32'h1000);
    queue_cmd(CMD_RESERVE, page_at(60), 32'(8) << PAGE_BITS);
    queue_cmd(CMD_RESERVE, page_at(56), 32'(8) << PAGE_BITS);  // ends on the map end
    queue_cmd(CMD_RESERVE, page_at(63), 32'(1) << PAGE_BITS);
    queue_cmd(CMD_FREE_REGION, page_at(10), 32'(2) << PAGE_BITS);
    queue_cmd(CMD_RESERVE, page_at(64), 32'h0);
    queue_cmd(CMD_RESERVE, 32'hFFFF_F000, 32'hFFFF_F000);
    queue_cmd(CMD_RESERVE, page_at(0), 32'(60) << PAGE_BITS);
    queue_cmd(CMD_ALLOC, 32'h0, 32'h0);                      // page 0 still free, the reserve above conflicted
    queue_cmd(CMD_FREE_REGION, page_at(56), 32'(8) << PAGE_BITS);

    // oversized map, three pages searchable, addresses wrap past 2^32
    set_cfg(32'hFFFF_E000, 17'h1FFFF, 17'd65533, 1'b1, 1'b1);
    queue_cmd(CMD_FREE_REGION, page_at(0), 32'(60) << PAGE_BITS);
    repeat (4) queue_cmd(CMD_ALLOC, 32'h0, 32'h0);

    random_phase(32'h0000_0000, 17'd16, 17'd0, 200, 1'b1, 1'b1);
    random_phase(32'h8000_0000, 17'd100, 17'd10, 200, 1'b0, 1'b0);
    random_phase(32'h4567_8000, 17'd256, 17'd255, 200, 1'b1, 1'b1);
    random_phase(32'hFFFF_F000, 17'd32, 17'd0, 150, 1'b1, 1'b0);
    random_phase(32'h1234_5678, 17'd40, 17'd3, 100, 1'b1, 1'b1);
    random_phase(32'h2000_0000, 17'h1FFFF, 17'h1FFFF, 150, 1'b1, 1'b1);
    random_phase(32'h0000_0000, 17'd1, 17'd0, 100, 1'b0, 1'b1);
    random_phase(32'h0300_0000, 17'd65536, 17'd65535, 150, 1'b1, 1'b1);
    random_phase(32'hFFFF_FFFF, 17'd8, 17'd0, 80, 1'b1, 1'b1);
    random_phase(32'h0000_1000, 17'd300, 17'h10000, 150, 1'b1, 1'b0);
    random_phase(32'h0000_0000, 17'd65536, 17'd0, 300, 1'b1, 1'b1);
    random_phase(32'h0000_0000, 17'd0, 17'h1FFFF, 70, 1'b1, 1'b1);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d commands over %0d register settings: alloc %0d, free page %0d, reserve %0d, free region %0d",
             n_op[0] + n_op[1] + n_op[2] + n_op[3], n_settings, n_op[CMD_ALLOC],
             n_op[CMD_FREE_PAGE], n_op[CMD_RESERVE], n_op[CMD_FREE_REGION]);
    $display("outcomes: ok %0d, no free page %0d, misaligned %0d, conflict %0d, out of range %0d",
             n_status[ST_OK], n_status[ST_NOFREE], n_status[ST_MISALIGN],
             n_status[ST_CONFLICT], n_status[ST_RANGE]);
    if (errors == 0) begin
      $display("PASS page_bitmap_allocator");
    end else begin
      $display("FAIL page_bitmap_allocator");
    end
    $finish;
  end

endmodule
